// ===== rtl/deq_pkg.sv =====
// shared types and constants for the deadline event queue
package deq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_RESULTS = 16;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    localparam logic [2:0] ST_ADDED  = 3'd0;
    localparam logic [2:0] ST_NULL   = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_FIRED  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    typedef struct packed {
        logic [31:0] deadline;
        logic [31:0] key;
        logic [15:0] handler;
    } entry_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key;
        logic [15:0] handler;
        logic [4:0]  removed;
        logic        last;
    } result_t;

endpackage

// ===== rtl/deq_entry_ram.sv =====
// entry store: one write port, one registered read port
module deq_entry_ram
    import deq_pkg::*;
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/deadline_event_queue_unit.sv =====
// top level of the deadline event queue
// The queue keeps up to 16 events in a one-port-read, one-port-write entry RAM in insertion
// order. An add, or a cancel with a null key or on an empty queue, is decided in the idle
// state and its result is valid on the next cycle; an item of unknown kind gives no result.
// A cancel walks the queue once, compacting kept entries in place, at one entry per cycle.
// A tick scans the queue to find the earliest due entry. For each fired entry it reads that
// entry, compacts the slots from it onwards, then scans again, for up to 16 events. A fired
// result is held until the following scan shows whether another one follows, so its last
// flag is known. One result is held in an output register; a full output register stalls
// the queue where it writes a result, and the next input is taken once the last result of
// the current one has been transferred.
module deadline_event_queue_unit
    import deq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // delay_seconds[15:0], event_key[47:16], handler_token[63:48]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[2:0], fired_key[34:3], fired_handler[50:35],
                                   // removed_count[55:51]
    output logic        m_tlast
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_PACK   = 7'b0000100,
        S_EMIT   = 7'b0001000,
        S_FIRE   = 7'b0010000,
        S_DRAIN  = 7'b0100000,
        S_WAIT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [31:0]       now_reg, now_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [1:0]        kind_reg, kind_next;
    logic [31:0]       key_reg, key_next;
    logic [CNT_W-1:0]  rd_ptr_reg, rd_ptr_next;   // next address issued
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;   // compaction write slot
    logic              rd_vld_reg, rd_vld_next;   // read data valid this cycle
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;   // address of data now on rd_data
    logic              found_reg, found_next;
    logic [31:0]       best_age_reg, best_age_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [4:0]        nfired_reg, nfired_next;
    logic [4:0]        removed_reg, removed_next;
    logic              ovld_reg, ovld_next;
    result_t           res_reg, res_next;
    result_t           pend_reg, pend_next;       // fired result waiting for its last flag
    logic              pend_vld_reg, pend_vld_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;

    deq_entry_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [31:0] age;
    logic        due;
    logic        out_free;
    logic        drop_hit;
    logic        more_fire;

    assign age       = now_reg - rd_data.deadline;
    assign due       = (age != 32'd0) && !age[31];
    assign out_free  = !ovld_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && !ovld_reg;
    assign more_fire = found_reg && (nfired_reg < 5'(MAX_RESULTS));
    // during a tick compaction the dropped slot is the chosen one
    assign drop_hit = (kind_reg == KIND_CANCEL) ? (rd_data.key == key_reg)
                                                : (rd_idx_reg == best_reg);

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_ptr_reg[IDX_W-1:0];
        found_next    = found_reg;
        best_age_next = best_age_reg;
        best_next     = best_reg;
        nfired_next   = nfired_reg;
        removed_next  = removed_reg;
        ovld_next     = ovld_reg && !m_tready;
        res_next      = res_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        wr_data       = '0;
        rd_addr       = rd_ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    kind_next    = s_tuser;
                    key_next     = s_tdata[47:16];
                    rd_ptr_next  = '0;
                    wr_ptr_next  = '0;
                    removed_next = '0;
                    nfired_next  = '0;
                    found_next   = 1'b0;
                    best_age_next = '0;
                    pend_vld_next = 1'b0;
                    res_next     = '0;
                    res_next.last = 1'b1;
                    case (s_tuser)
                        KIND_ADD:
                        begin
                            ovld_next = 1'b1;
                            if (s_tdata[47:16] == 32'd0)
                            begin
                                res_next.status = ST_NULL;
                            end
                            else if (count_reg >= CNT_W'(QUEUE_DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                res_next.status = ST_ADDED;
                                wr_en           = 1'b1;
                                wr_data.deadline = now_reg + {16'd0, s_tdata[15:0]};
                                wr_data.key     = s_tdata[47:16];
                                wr_data.handler = s_tdata[63:48];
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        KIND_CANCEL:
                        begin
                            if (s_tdata[47:16] == 32'd0 || count_reg == '0)
                            begin
                                res_next.status = ST_DONE;
                                ovld_next       = 1'b1;
                            end
                            else
                            begin
                                state_next  = S_PACK;
                                rd_ptr_next = CNT_W'(1);
                                rd_vld_next = 1'b1;
                                rd_idx_next = '0;
                                rd_addr     = '0;
                            end
                        end
                        KIND_TICK:
                        begin
                            now_next   = now_reg + 32'd1;
                            state_next = S_SCAN;
                            rd_addr    = '0;
                            rd_ptr_next = CNT_W'(1);
                            rd_vld_next = (count_reg != '0);
                            rd_idx_next = '0;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // one entry per cycle through the read port, keep the oldest due one
                if (rd_vld_reg)
                begin
                    if (due && (!found_reg || age > best_age_reg))
                    begin
                        found_next    = 1'b1;
                        best_age_next = age;
                        best_next     = rd_idx_reg;
                    end
                end
                if (rd_ptr_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (pend_vld_reg)
                begin
                    // the held fired result is last unless another one fires now
                    if (out_free)
                    begin
                        res_next      = pend_reg;
                        res_next.last = !more_fire;
                        ovld_next     = 1'b1;
                        pend_vld_next = 1'b0;
                        if (more_fire)
                        begin
                            rd_addr    = best_reg;
                            state_next = S_FIRE;
                        end
                        else
                        begin
                            state_next = S_WAIT;
                        end
                    end
                end
                else if (found_reg)
                begin
                    // read the chosen entry for its key and handler
                    rd_addr    = best_reg;
                    state_next = S_FIRE;
                end
                else if (out_free)
                begin
                    res_next        = '0;
                    res_next.status = ST_DONE;
                    res_next.last   = 1'b1;
                    ovld_next       = 1'b1;
                    state_next      = S_WAIT;
                end
            end

            S_FIRE:
            begin
                pend_next         = '0;
                pend_next.status  = ST_FIRED;
                pend_next.key     = rd_data.key;
                pend_next.handler = rd_data.handler;
                pend_vld_next     = 1'b1;
                nfired_next       = nfired_reg + 1'b1;
                // compact from the chosen slot onwards
                wr_ptr_next = {1'b0, best_reg};
                rd_ptr_next = {1'b0, best_reg} + 1'b1;
                rd_addr     = best_reg;
                rd_idx_next = best_reg;
                rd_vld_next = 1'b1;
                state_next  = S_PACK;
            end

            S_PACK:
            begin
                // walk entries, dropping matches and closing gaps
                if (rd_vld_reg)
                begin
                    if (drop_hit)
                    begin
                        if (removed_reg != 5'd31)
                        begin
                            removed_next = removed_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = wr_ptr_reg[IDX_W-1:0];
                        wr_data     = rd_data;
                        wr_ptr_next = wr_ptr_reg + 1'b1;
                    end
                end
                if (rd_ptr_reg < count_reg)
                begin
                    rd_vld_next = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                end
                else if (!rd_vld_reg)
                begin
                    count_next = wr_ptr_reg;
                    if (kind_reg == KIND_CANCEL)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next    = S_SCAN;
                        found_next    = 1'b0;
                        best_age_next = '0;
                        rd_ptr_next   = CNT_W'(1);
                        rd_addr       = '0;
                        rd_idx_next   = '0;
                        rd_vld_next   = (wr_ptr_reg != '0);
                        if (wr_ptr_reg == '0)
                        begin
                            rd_ptr_next = '0;
                        end
                    end
                end
            end

            S_DRAIN:
            begin
                // final result of a cancel
                if (out_free)
                begin
                    res_next         = '0;
                    res_next.status  = ST_DONE;
                    res_next.removed = removed_reg;
                    res_next.last    = 1'b1;
                    ovld_next        = 1'b1;
                    state_next       = S_WAIT;
                end
            end

            S_WAIT:
            begin
                if (!ovld_next)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {res_reg.removed, res_reg.handler, res_reg.key, res_reg.status};
    assign m_tlast  = res_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            now_reg       <= '0;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            nfired_reg    <= '0;
            ovld_reg      <= 1'b0;
            pend_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            nfired_reg    <= nfired_next;
            ovld_reg      <= ovld_next;
            pend_vld_reg  <= pend_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        rd_idx_reg   <= rd_idx_next;
        best_age_reg <= best_age_next;
        best_reg     <= best_next;
        removed_reg  <= removed_next;
        res_reg      <= res_next;
        pend_reg     <= pend_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == KIND_TICK) |=> now_reg == $past(now_reg) + 32'd1)
        else $error("tick did not advance time");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PACK) |-> wr_ptr_reg <= rd_ptr_reg)
        else $error("compaction write passed read");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while waiting for transfer");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the deadline event queue unit
module testbench;
    import deq_pkg::*;

    class deq_scoreboard;
        logic [31:0] now_secs;
        logic [31:0] slot_deadline[QUEUE_DEPTH];
        logic [31:0] slot_key[QUEUE_DEPTH];
        logic [15:0] slot_handler[QUEUE_DEPTH];
        int          slot_count;
        result_t     expected_q[$];
        int          errors;

        function new();
            now_secs   = '0;
            slot_count = 0;
            errors     = 0;
        endfunction

        function void push_result(logic [2:0] st, logic [31:0] k, logic [15:0] h,
                                  logic [4:0] rm, logic lst);
            result_t r;
            r.status  = st;
            r.key     = k;
            r.handler = h;
            r.removed = rm;
            r.last    = lst;
            expected_q.push_back(r);
        endfunction

        function void drop_slot(int idx);
            for (int j = idx; j + 1 < slot_count; j++) begin
                slot_deadline[j] = slot_deadline[j + 1];
                slot_key[j]      = slot_key[j + 1];
                slot_handler[j]  = slot_handler[j + 1];
            end
            slot_count--;
        endfunction

        function void note_item(logic [1:0] kind, logic [15:0] delay, logic [31:0] k,
                                logic [15:0] h);
            int          removed;
            int          idx;
            int          fired;
            int          best;
            logic [31:0] age;
            logic [31:0] best_age;
            bit          found;
            removed = 0;
            fired   = 0;
            case (kind)
                KIND_ADD:
                    if (k == '0)
                        push_result(ST_NULL, '0, '0, '0, 1'b1);
                    else if (slot_count >= QUEUE_DEPTH)
                        push_result(ST_FULL, '0, '0, '0, 1'b1);
                    else
                    begin
                        slot_deadline[slot_count] = now_secs + delay;
                        slot_key[slot_count]      = k;
                        slot_handler[slot_count]  = h;
                        slot_count++;
                        push_result(ST_ADDED, '0, '0, '0, 1'b1);
                    end
                KIND_CANCEL:
                begin
                    idx = 0;
                    if (k != '0)
                        while (idx < slot_count)
                            if (slot_key[idx] == k)
                            begin
                                drop_slot(idx);
                                removed++;
                            end
                            else
                                idx++;
                    push_result(ST_DONE, '0, '0, 5'(removed), 1'b1);
                end
                KIND_TICK:
                begin
                    now_secs = now_secs + 1;
                    while (fired < MAX_RESULTS)
                    begin
                        found    = 1'b0;
                        best     = 0;
                        best_age = '0;
                        for (int i = 0; i < slot_count; i++)
                        begin
                            age = now_secs - slot_deadline[i];
                            if (age >= 1 && age <= 32'h7fff_ffff && (!found || age > best_age))
                            begin
                                found    = 1'b1;
                                best     = i;
                                best_age = age;
                            end
                        end
                        if (!found)
                            break;
                        push_result(ST_FIRED, slot_key[best], slot_handler[best], '0, 1'b0);
                        drop_slot(best);
                        fired++;
                    end
                    if (fired == 0)
                        push_result(ST_DONE, '0, '0, '0, 1'b1);
                    else
                        expected_q[expected_q.size() - 1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer, status %0d", got.status);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.key !== want.key)
            begin
                $error("fired_key: expected %h, got %h", want.key, got.key);
                errors++;
            end
            if (got.handler !== want.handler)
            begin
                $error("fired_handler: expected %h, got %h", want.handler, got.handler);
                errors++;
            end
            if (got.removed !== want.removed)
            begin
                $error("removed_count: expected %0d, got %0d", want.removed, got.removed);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;

    int unsigned send_idle;
    int unsigned recv_idle;
    deq_scoreboard queue_sb = new();

    deadline_event_queue_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status  = m_tdata[2:0];
            got.key     = m_tdata[34:3];
            got.handler = m_tdata[50:35];
            got.removed = m_tdata[55:51];
            got.last    = m_tlast;
            queue_sb.check_result(got);
        end
    end

    task automatic send_item(logic [1:0] kind, logic [15:0] delay, logic [31:0] k,
                             logic [15:0] h);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {h, k, delay};
        do
            @(posedge clk);
        while (!s_tready);
        queue_sb.note_item(kind, delay, k, h);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (queue_sb.pending() != 0)
            @(posedge clk);
        // all results are in; the unit goes back to idle before the next phase
        repeat (60) @(posedge clk);
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [31:0] k;
        logic [15:0] delay;
        pick = $urandom_range(99);
        k = 32'($urandom_range(6, 1));
        if ($urandom_range(19) == 0)
            k = $urandom;
        else if ($urandom_range(29) == 0)
            k = '0;
        delay = 16'($urandom_range(5));
        if ($urandom_range(14) == 0)
            delay = 16'($urandom);
        if (pick < 45)
            send_item(KIND_ADD, delay, k, 16'($urandom));
        else if (pick < 60)
            send_item(KIND_CANCEL, 16'($urandom), k, 16'($urandom));
        else if (pick < 97)
            send_item(KIND_TICK, 16'($urandom), $urandom, 16'($urandom));
        else
            send_item(2'd3, 16'($urandom), $urandom, 16'($urandom));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        send_idle = 14;
        recv_idle = 48;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: null key, extremes, immediate fire, empty tick, cancel cases
        send_item(KIND_ADD, 16'd5, 32'h0, 16'h1234);
        send_item(KIND_ADD, 16'hffff, 32'hffff_ffff, 16'hffff);
        send_item(KIND_ADD, 16'd0, 32'h0000_0001, 16'h0000);
        send_item(KIND_ADD, 16'd0, 32'h0000_0002, 16'h5a5a);
        send_item(KIND_TICK, 16'h0, 32'h0, 16'h0);
        send_item(KIND_TICK, 16'hffff, 32'hffff_ffff, 16'hffff);
        send_item(KIND_CANCEL, 16'h0, 32'h0, 16'h0);
        send_item(KIND_CANCEL, 16'h0, 32'hffff_ffff, 16'h0);
        send_item(2'd3, 16'hffff, 32'hffff_ffff, 16'hffff);
        // fill to capacity, overflow, then clear with one cancel
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_item(KIND_ADD, 16'(i % 3), 32'h0000_0007, 16'(i));
        send_item(KIND_ADD, 16'd1, 32'h0000_0008, 16'h0001);
        send_item(KIND_CANCEL, 16'h0, 32'h0000_0007, 16'h0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 14 : (phase == 1) ? 48 : 0;
            recv_idle = (phase == 0) ? 48 : (phase == 1) ? 14 : 0;
            for (int n = 0; n < 50; n++)
                random_item();
            wait_drained();
        end

        if (queue_sb.errors == 0 && queue_sb.pending() == 0)
            $display("deadline_event_queue_unit: match");
        else
            $display("deadline_event_queue_unit: mismatch");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("deadline_event_queue_unit: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/deq_pkg.sv
rtl/deq_entry_ram.sv
rtl/deadline_event_queue_unit.sv
tb/sv/testbench.sv
